[rtl/basr_pkg.sv]
// Shared types and constants for the bridge converter serial reader.
// No dependencies; every other file of the block but basr_in_if imports this package.
package basr_pkg;

    localparam int INTERVAL_W  = 32;
    localparam int GAIN_W      = 3;
    localparam int PTICK_W     = 8;
    localparam int DATA_BITS   = 24;
    localparam int SHIFT_W     = 28;
    localparam int BITS_W      = 5;
    localparam int OVF_OUT_W   = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    localparam int DEF_READY_BACKOFF = 8;
    localparam int DEF_OVERFLOW_BITS = 16;

    localparam logic [GAIN_W-1:0]  GAIN_MIN = 3'd1;
    localparam logic [GAIN_W-1:0]  GAIN_MAX = 3'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN     = 2'd0,
        CFG_INTERVAL = 2'd1,
        CFG_PULSE    = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        PH_WAIT = 2'd0,
        PH_HIGH = 2'd1,
        PH_LOW  = 2'd2
    } t_phase;

    typedef struct packed {
        logic [GAIN_W-1:0]     gain;
        logic [INTERVAL_W-1:0] interval;
        logic [PTICK_W-1:0]    pulse;
    } t_cfg;

    typedef struct packed {
        logic                  valid;
        logic [INTERVAL_W-1:0] interval;
    } t_restart;

    typedef struct packed {
        logic                        clock_level;
        logic                        sample_valid;
        logic signed [DATA_BITS-1:0] sample_value;
        logic                        sample_fault;
        logic [OVF_OUT_W-1:0]        overflow_total;
    } t_result;

endpackage

[rtl/basr_in_if.sv]
// Input channel: one beat per tick carrying the sampled data line level.
// Depends on nothing beyond the language itself.
interface basr_in_if;
    logic valid;
    logic ready;
    logic data_level;

    modport source (output valid, output data_level, input ready);
    modport sink   (input valid, input data_level, output ready);
endinterface

[rtl/basr_out_if.sv]
// Output channel: one result beat per tick.
// Depends on basr_pkg for the field widths.
interface basr_out_if;
    import basr_pkg::*;

    logic                        valid;
    logic                        ready;
    logic                        clock_level;
    logic                        sample_valid;
    logic signed [DATA_BITS-1:0] sample_value;
    logic                        sample_fault;
    logic [OVF_OUT_W-1:0]        overflow_total;

    modport source (output valid, output clock_level, output sample_valid,
                    output sample_value, output sample_fault,
                    output overflow_total, input ready);
    modport sink   (input valid, input clock_level, input sample_valid,
                    input sample_value, input sample_fault,
                    input overflow_total, output ready);
endinterface

[rtl/bridge_adc_serial_reader.sv]
// Serial readout for a 24-bit bridge converter; top level of the block.
// A result beat appears in the output register in the cycle after its input beat is taken.
// Throughput: one beat per cycle while the output is not stalled, set by the sequencer update in basr_core.
// Input is held off only while a result beat waits and the sink is not ready.
// Reset is synchronous, active low: gain 1, interval 0 (clock held high), pulse 1.
// Read state, the poll countdown and the overflow count clear to zero; the read gain resets to 1.
module bridge_adc_serial_reader #(
    parameter int READY_BACKOFF = basr_pkg::DEF_READY_BACKOFF,
    parameter int OVERFLOW_BITS = basr_pkg::DEF_OVERFLOW_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [basr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [basr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    basr_in_if.sink                         i_in,
    basr_out_if.source                      o_out
);
    import basr_pkg::*;

    t_cfg     w_cfg;
    t_restart w_restart;
    t_result  w_res;
    logic     w_free;
    logic     w_accept;

    assign i_in.ready = w_free;
    assign w_accept   = i_in.valid && w_free;

    basr_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg),
        .o_restart  (w_restart)
    );

    basr_core #(
        .READY_BACKOFF (READY_BACKOFF),
        .OVERFLOW_BITS (OVERFLOW_BITS)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_restart (w_restart),
        .i_step    (w_accept),
        .i_level   (i_in.data_level),
        .o_res     (w_res)
    );

    basr_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_accept),
        .i_res   (w_res),
        .o_free  (w_free),
        .o_out   (o_out)
    );

    a_err_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.sample_fault |-> o_out.sample_valid)
        else $error("sample fault flagged without a completed read");

    a_value_only_good: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.sample_value != '0) |->
        o_out.sample_valid && !o_out.sample_fault)
        else $error("sample value nonzero outside a good read");

    a_power_down_clock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && (w_cfg.interval == '0) && !w_restart.valid |=>
        o_out.valid && o_out.clock_level)
        else $error("clock line not high while powered down");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |-> !i_in.ready)
        else $error("input beat taken while a result beat is stalled");

endmodule

[rtl/basr_cfg.sv]
// Configuration registers and the restart event raised by an interval write.
// Depends on basr_pkg.
module basr_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [basr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [basr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output basr_pkg::t_cfg                  o_cfg,
    output basr_pkg::t_restart              o_restart
);
    import basr_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg              = r_cfg;
        o_restart.valid    = 1'b0;
        o_restart.interval = i_cfg_data[INTERVAL_W-1:0];
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_GAIN: begin
                    n_cfg.gain = i_cfg_data[GAIN_W-1:0];
                end
                CFG_INTERVAL: begin
                    n_cfg.interval  = i_cfg_data[INTERVAL_W-1:0];
                    o_restart.valid = 1'b1;
                end
                CFG_PULSE: begin
                    n_cfg.pulse = i_cfg_data[PTICK_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain     <= GAIN_MIN;
            r_cfg.interval <= '0;
            r_cfg.pulse    <= PTICK_W'(1);
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/basr_core.sv]
// Read sequencer: pulse timing, bit capture, polling and overflow count.
// Depends on basr_pkg; advances one tick per accepted input beat unless a restart is raised.
module basr_core #(
    parameter int READY_BACKOFF = basr_pkg::DEF_READY_BACKOFF,
    parameter int OVERFLOW_BITS = basr_pkg::DEF_OVERFLOW_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  basr_pkg::t_cfg     i_cfg,
    input  basr_pkg::t_restart i_restart,
    input  logic               i_step,
    input  logic               i_level,
    output basr_pkg::t_result  o_res
);
    import basr_pkg::*;

    localparam int PC_W = INTERVAL_W + $clog2(READY_BACKOFF + 1);
    localparam int OVW  = (OVERFLOW_BITS > OVF_OUT_W) ? OVERFLOW_BITS : OVF_OUT_W;

    t_phase               r_phase, n_phase;
    logic [PC_W-1:0]      r_pcd, n_pcd;
    logic [PTICK_W-1:0]   r_pc, n_pc;
    logic [BITS_W-1:0]    r_bl, n_bl;
    logic [SHIFT_W-1:0]   r_sw, n_sw;
    logic                 r_pend, n_pend;
    logic [OVERFLOW_BITS-1:0] r_ovf, n_ovf;
    logic [GAIN_W-1:0]    r_rgain, n_rgain;

    logic [PTICK_W-1:0]   w_eff_pulse;
    logic [GAIN_W-1:0]    w_eff_gain;
    logic [PC_W-1:0]      w_backoff;
    logic [OVW-1:0]       w_ovf_wide;

    assign w_eff_pulse = (i_cfg.pulse == '0) ? PTICK_W'(1) : i_cfg.pulse;
    assign w_eff_gain  = (i_cfg.gain < GAIN_MIN) ? GAIN_MIN :
                         (i_cfg.gain > GAIN_MAX) ? GAIN_MAX : i_cfg.gain;
    assign w_backoff   = PC_W'(i_cfg.interval) * PC_W'(READY_BACKOFF);

    always_comb begin
        logic [SHIFT_W-1:0] mask;
        logic [SHIFT_W-1:0] shifted;

        n_phase = r_phase;
        n_pcd   = r_pcd;
        n_pc    = r_pc;
        n_bl    = r_bl;
        n_sw    = r_sw;
        n_pend  = r_pend;
        n_ovf   = r_ovf;
        n_rgain = r_rgain;
        mask    = '0;
        shifted = '0;

        o_res.clock_level  = 1'b1;
        o_res.sample_valid = 1'b0;
        o_res.sample_value = '0;
        o_res.sample_fault = 1'b0;

        if (i_cfg.interval != '0) begin
            o_res.clock_level = (r_phase == PH_HIGH);

            unique case (r_phase)
                PH_HIGH: begin
                    if (n_pc != '0) n_pc = n_pc - PTICK_W'(1);
                    if (n_pc == '0) begin
                        n_phase = PH_LOW;
                        n_pc    = w_eff_pulse;
                    end
                end
                PH_LOW: begin
                    if (n_pc != '0) n_pc = n_pc - PTICK_W'(1);
                    if (n_pc == '0) begin
                        n_sw = {n_sw[SHIFT_W-2:0], i_level};
                        if (n_bl != '0) n_bl = n_bl - BITS_W'(1);
                        if (n_bl == '0) begin
                            mask    = (SHIFT_W'(1) << n_rgain) - SHIFT_W'(1);
                            shifted = n_sw >> n_rgain;
                            o_res.sample_valid = 1'b1;
                            if ((n_sw & mask) != mask) begin
                                o_res.sample_fault = 1'b1;
                            end else begin
                                o_res.sample_value = shifted[DATA_BITS-1:0];
                            end
                            n_phase = PH_WAIT;
                            n_pc    = '0;
                            n_bl    = '0;
                            n_sw    = '0;
                            n_pend  = 1'b0;
                        end else begin
                            n_phase = PH_HIGH;
                            n_pc    = w_eff_pulse;
                        end
                    end
                end
                default: begin
                end
            endcase

            if (n_pcd != '0) n_pcd = n_pcd - PC_W'(1);
            if (n_pcd == '0) begin
                if (n_pend && (n_ovf != '1)) n_ovf = n_ovf + OVERFLOW_BITS'(1);
                if (!i_level) begin
                    if (!n_pend) begin
                        n_pend  = 1'b1;
                        n_rgain = w_eff_gain;
                        n_phase = PH_HIGH;
                        n_pc    = w_eff_pulse;
                        n_bl    = BITS_W'(DATA_BITS) + BITS_W'(w_eff_gain);
                        n_sw    = '0;
                    end
                    n_pcd = w_backoff;
                end else begin
                    n_pcd = PC_W'(i_cfg.interval);
                end
            end
        end

        w_ovf_wide           = OVW'(n_ovf);
        o_res.overflow_total = w_ovf_wide[OVF_OUT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_WAIT;
            r_pcd   <= '0;
            r_pc    <= '0;
            r_bl    <= '0;
            r_sw    <= '0;
            r_pend  <= 1'b0;
            r_ovf   <= '0;
            r_rgain <= GAIN_MIN;
        end else if (i_restart.valid) begin
            r_phase <= PH_WAIT;
            r_pcd   <= PC_W'(i_restart.interval);
            r_pc    <= '0;
            r_bl    <= '0;
            r_sw    <= '0;
            r_pend  <= 1'b0;
            if (i_restart.interval != '0) r_ovf <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_pcd   <= n_pcd;
            r_pc    <= n_pc;
            r_bl    <= n_bl;
            r_sw    <= n_sw;
            r_pend  <= n_pend;
            r_ovf   <= n_ovf;
            r_rgain <= n_rgain;
        end
    end

endmodule

[rtl/basr_out.sv]
// Output register that holds one result beat until the sink takes it.
// Depends on basr_pkg and basr_out_if.
module basr_out (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  basr_pkg::t_result i_res,
    output logic              o_free,
    basr_out_if.source        o_out
);
    import basr_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_free = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_out.valid          = r_valid;
    assign o_out.clock_level    = r_res.clock_level;
    assign o_out.sample_valid   = r_res.sample_valid;
    assign o_out.sample_value   = r_res.sample_value;
    assign o_out.sample_fault   = r_res.sample_fault;
    assign o_out.overflow_total = r_res.overflow_total;

endmodule
